@@ rtl/core/aplm_pkg.sv @@
// Shared types, constants and helpers for the audio peak level meter.
`timescale 1ns / 1ps
`default_nettype none

package aplm_pkg;

  localparam int LEVEL_FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF     = 4;
  localparam int OUT_FRAC_BITS       = 16;

  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 32;
  localparam int MIN_W    = 17;
  localparam int LEVEL_W  = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] FS_U8  = 32'd255;
  localparam logic [31:0] FS_S8  = 32'd127;
  localparam logic [31:0] FS_U16 = 32'd65535;
  localparam logic [31:0] FS_S16 = 32'd32767;
  localparam logic [31:0] FS_U32 = 32'hffff_ffff;
  localparam logic [31:0] FS_S32 = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    WIDTH_8   = 2'd0,
    WIDTH_16  = 2'd1,
    WIDTH_32  = 2'd2,
    WIDTH_BAD = 2'd3
  } width_e;

  typedef enum logic [1:0] {
    KIND_UNSIGNED = 2'd0,
    KIND_SIGNED   = 2'd1,
    KIND_FLOAT    = 2'd2,
    KIND_BAD      = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_WIDTH = 2'd0,
    CFG_SAMPLE_KIND  = 2'd1,
    CFG_BIG_ENDIAN   = 2'd2,
    CFG_MIN_LEVEL    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    width_e           sample_width;
    kind_e            sample_kind;
    logic             big_endian;
    logic [MIN_W-1:0] min_level;
  } cfg_t;

  // One finished buffer handed from the front to the back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] peak;
    logic [SAMPLE_W-1:0] full;
    logic                supported;
  } job_t;

  typedef struct packed {
    logic full;
    logic almost_full;
  } q_status_t;

  // Zero marks an unsupported format.
  function automatic logic [31:0] full_scale(width_e w, kind_e k);
    logic [31:0] fs;
    fs = '0;
    unique case (w)
      WIDTH_8: begin
        if (k == KIND_UNSIGNED) fs = FS_U8;
        else if (k == KIND_SIGNED) fs = FS_S8;
      end
      WIDTH_16: begin
        if (k == KIND_UNSIGNED) fs = FS_U16;
        else if (k == KIND_SIGNED) fs = FS_S16;
      end
      WIDTH_32: begin
        if (k == KIND_UNSIGNED) fs = FS_U32;
        else if (k == KIND_SIGNED || k == KIND_FLOAT) fs = FS_S32;
      end
      default: fs = '0;
    endcase
    return fs;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/aplm_if.sv @@
// Channel interfaces of the audio peak level meter: bytes, results, config writes.
`timescale 1ns / 1ps
`default_nettype none

interface aplm_pcm_if;
  logic                             valid;
  logic                             ready;
  logic [aplm_pkg::BYTE_W-1:0]      data_byte;
  logic                             last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aplm_meter_if;
  logic                               valid;
  logic                               ready;
  logic signed [aplm_pkg::LEVEL_W-1:0] level;
  logic [aplm_pkg::SAMPLE_W-1:0]      peak;
  modport source (output valid, output level, output peak, input ready);
  modport sink   (input valid, input level, input peak, output ready);
endinterface

interface aplm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [aplm_pkg::CFG_IDX_W-1:0]    index;
  logic [aplm_pkg::MIN_W-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aplm_front.sv @@
// Front end: gathers bytes into samples, forms magnitudes, tracks the buffer peak.
`timescale 1ns / 1ps
`default_nettype none

module aplm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  aplm_pkg::cfg_t       cfg_regs,
  aplm_pcm_if.sink             pcm,
  input  aplm_pkg::q_status_t  q_stat,
  output logic                 push,
  output aplm_pkg::job_t       push_job
);

  logic [23:0] byte_gather;
  logic [1:0]  byte_position;
  logic [31:0] running_peak;

  // sample stage register
  logic        a_valid;
  logic        a_last;
  logic        a_mag_valid;
  logic [31:0] a_mag;

  logic        accept;
  logic [31:0] full;
  logic        supported;
  logic        complete;
  logic [31:0] raw;
  logic [31:0] mag;
  logic [31:0] neg;
  logic [31:0] peak_now;
  logic [7:0]  b;

  function automatic logic [31:0] float_mag(logic [31:0] bits);
    logic [7:0]  ex;
    logic [31:0] man;
    logic [31:0] res;
    ex  = bits[30:23];
    man = {8'd0, 1'b1, bits[22:0]};
    if (ex == 8'd255) res = 32'hffff_ffff;
    else if (ex == 8'd0) res = '0;
    else if (ex >= 8'd128) res = 32'hffff_ffff;
    else if (ex >= 8'd119) res = man << (ex - 8'd119);
    else if ((8'd119 - ex) >= 8'd32) res = '0;
    else res = man >> (8'd119 - ex);
    return res;
  endfunction

  assign b         = pcm.data_byte;
  assign full      = aplm_pkg::full_scale(cfg_regs.sample_width, cfg_regs.sample_kind);
  assign supported = (full != '0);

  // Hold off while a pending buffer end could find the queue full.
  assign pcm.ready = !q_stat.full && !(a_valid && a_last && q_stat.almost_full);
  assign accept    = pcm.valid && pcm.ready;

  always_comb begin
    complete = 1'b0;
    raw      = '0;
    unique case (cfg_regs.sample_width)
      aplm_pkg::WIDTH_8: begin
        complete = 1'b1;
        raw      = {24'd0, b};
      end
      aplm_pkg::WIDTH_16: begin
        complete = (byte_position != 2'd0);
        raw = cfg_regs.big_endian ? {16'd0, byte_gather[7:0], b}
                                  : {16'd0, b, byte_gather[7:0]};
      end
      default: begin
        complete = (byte_position == 2'd3);
        raw = cfg_regs.big_endian
            ? {byte_gather[7:0], byte_gather[15:8], byte_gather[23:16], b}
            : {b, byte_gather[23:16], byte_gather[15:8], byte_gather[7:0]};
      end
    endcase
  end

  assign neg = ~raw + 32'd1;

  always_comb begin
    mag = raw;
    if (cfg_regs.sample_kind == aplm_pkg::KIND_FLOAT) begin
      mag = float_mag(raw);
    end else if (cfg_regs.sample_kind == aplm_pkg::KIND_SIGNED) begin
      unique case (cfg_regs.sample_width)
        aplm_pkg::WIDTH_8:  mag = raw[7]  ? {24'd0, neg[7:0]}  : raw;
        aplm_pkg::WIDTH_16: mag = raw[15] ? {16'd0, neg[15:0]} : raw;
        default:            mag = raw[31] ? neg : raw;
      endcase
    end
  end

  assign peak_now = (a_mag_valid && a_mag > running_peak) ? a_mag : running_peak;

  assign push               = a_valid && a_last;
  assign push_job.peak      = peak_now;
  assign push_job.full      = full;
  assign push_job.supported = supported;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_gather   <= '0;
      byte_position <= '0;
      running_peak  <= '0;
      a_valid       <= 1'b0;
      a_last        <= 1'b0;
      a_mag_valid   <= 1'b0;
      a_mag         <= '0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        a_last      <= pcm.last_byte;
        a_mag_valid <= supported && complete;
        a_mag       <= mag;
        if (pcm.last_byte || (supported && complete)) begin
          byte_gather   <= '0;
          byte_position <= '0;
        end else if (supported) begin
          case (byte_position)
            2'd0:    byte_gather[7:0]   <= b;
            2'd1:    byte_gather[15:8]  <= b;
            default: byte_gather[23:16] <= b;
          endcase
          byte_position <= byte_position + 2'd1;
        end
      end
      if (a_valid) begin
        running_peak <= a_last ? '0 : peak_now;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/aplm_queue.sv @@
// Short queue of finished buffers between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module aplm_queue #(
  parameter int DEPTH = aplm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  aplm_pkg::job_t       push_job,
  input  logic                 pop,
  output logic                 pop_valid,
  output aplm_pkg::job_t       pop_job,
  output aplm_pkg::q_status_t  q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  aplm_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && pop_valid;

  assign pop_valid          = (count != '0);
  assign pop_job            = entries[rd_ptr];
  assign q_stat.full        = (count == CW'(DEPTH));
  assign q_stat.almost_full = (count == CW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/aplm_back.sv @@
// Back end: scales the clamped peak to a level, subtracts min level, holds the result.
`timescale 1ns / 1ps
`default_nettype none

module aplm_back #(
  parameter int LEVEL_FRAC_BITS = aplm_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  aplm_pkg::cfg_t  cfg_regs,
  input  logic            pop_valid,
  input  aplm_pkg::job_t  pop_job,
  output logic            pop,
  aplm_meter_if.source    meter
);

  localparam int OF   = aplm_pkg::OUT_FRAC_BITS;
  localparam int KEEP = (LEVEL_FRAC_BITS < OF) ? LEVEL_FRAC_BITS : OF;
  // Drop the output fraction bits that lie below LEVEL_FRAC_BITS.
  localparam logic [OF-1:0] FRAC_MASK = ~((OF'(1) << (OF - KEEP)) - OF'(1));

  typedef enum logic {
    S_IDLE,
    S_DONE
  } state_t;

  state_t          state;
  logic [31:0]     pk;
  logic [31:0]     scale;
  logic            sup;
  logic [17:0]     held_level;

  logic            out_valid;
  logic [17:0]     out_level;
  logic [31:0]     out_peak;

  logic [31:0]     clamped;
  logic [OF-1:0]   expand;
  logic [OF:0]     frac;
  logic [17:0]     lvl;

  assign pop = (state == S_IDLE) && pop_valid;

  assign clamped = (pop_job.peak < pop_job.full) ? pop_job.peak : pop_job.full;

  // Every full scale is 2^n - 1, and below it peak / (2^n - 1) in binary is the
  // n-bit peak repeated without end: take its leading fraction bits.
  always_comb begin
    case (scale)
      aplm_pkg::FS_S8:  expand = {pk[6:0], pk[6:0], pk[6:5]};
      aplm_pkg::FS_U8:  expand = {pk[7:0], pk[7:0]};
      aplm_pkg::FS_S16: expand = {pk[14:0], pk[14]};
      aplm_pkg::FS_U16: expand = pk[15:0];
      aplm_pkg::FS_S32: expand = pk[30:15];
      default:          expand = pk[31:16];
    endcase
  end

  // A peak at full scale is exactly 1.0.
  assign frac = (pk == scale) ? {1'b1, OF'(0)} : {1'b0, expand & FRAC_MASK};
  assign lvl  = {1'b0, frac} - {1'b0, cfg_regs.min_level};

  assign meter.valid = out_valid;
  assign meter.level = out_level;
  assign meter.peak  = out_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_level <= '0;
      out_valid  <= 1'b0;
      out_level  <= '0;
      out_peak   <= '0;
      pk         <= '0;
      scale      <= '0;
      sup        <= 1'b0;
    end else begin
      if (meter.ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            sup   <= pop_job.supported;
            pk    <= pop_job.supported ? clamped : '0;
            scale <= pop_job.full;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || meter.ready) begin
            out_valid <= 1'b1;
            out_peak  <= pk;
            if (sup) begin
              held_level <= lvl;
              out_level  <= lvl;
            end else begin
              out_level  <= held_level;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/audio_peak_level_meter.sv @@
// Top level of the audio peak level meter: config registers, front, queue and back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one PCM byte per cycle on pcm and gathers bytes into 8, 16 or 32 bit
// samples (unsigned, signed or 32-bit float, either byte order), tracking the
// peak magnitude of the buffer. The byte flagged last_byte closes a buffer and
// yields one beat on meter: the peak clamped to full scale and the level
// peak/full_scale, truncated to LEVEL_FRAC_BITS fraction bits, minus min_level,
// given with 16 fractional bits. The front accepts a byte every cycle; the back
// clamps each buffer's peak in S_IDLE, forms the level in S_DONE, and up to
// QUEUE_DEPTH finished buffers wait between the two, so the front stalls only
// on a run of one-byte buffers or while meter is held off. Unsupported
// formats return the previous level with a peak of zero. Write configuration
// on cfg only while no buffer is in flight.
module audio_peak_level_meter #(
  parameter int LEVEL_FRAC_BITS = aplm_pkg::LEVEL_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH     = aplm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  aplm_cfg_if.sink      cfg,
  aplm_pcm_if.sink      pcm,
  aplm_meter_if.source  meter
);

  aplm_pkg::cfg_t       cfg_regs;
  aplm_pkg::job_t       push_job;
  aplm_pkg::job_t       pop_job;
  aplm_pkg::q_status_t  q_stat;
  logic                 push;
  logic                 pop;
  logic                 pop_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.sample_width <= aplm_pkg::WIDTH_16;
      cfg_regs.sample_kind  <= aplm_pkg::KIND_SIGNED;
      cfg_regs.big_endian   <= 1'b0;
      cfg_regs.min_level    <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (aplm_pkg::cfg_idx_e'(cfg.index))
        aplm_pkg::CFG_SAMPLE_WIDTH: cfg_regs.sample_width <= aplm_pkg::width_e'(cfg.data[1:0]);
        aplm_pkg::CFG_SAMPLE_KIND:  cfg_regs.sample_kind  <= aplm_pkg::kind_e'(cfg.data[1:0]);
        aplm_pkg::CFG_BIG_ENDIAN:   cfg_regs.big_endian   <= cfg.data[0];
        aplm_pkg::CFG_MIN_LEVEL:    cfg_regs.min_level    <= cfg.data;
        default: ;
      endcase
    end
  end

  aplm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .pcm      (pcm),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  aplm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .q_stat    (q_stat)
  );

  aplm_back #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop       (pop),
    .meter     (meter)
  );

  // A buffer end must always find room in the queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("buffer end pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("back popped an empty queue");

  // A supported job always carries a nonzero full scale.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (pop && pop_job.supported) |-> (pop_job.full != '0))
    else $error("supported job with zero full scale");

endmodule

`default_nettype wire
